// ===== rtl/bmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_pkg: shared types, constants and the alpha table
// Holds the result codes, the front-to-back job record and the ROM function.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int MaxDimDefault   = 4096;
  localparam int ExpDepthDefault = 1536;
  localparam int HdrLen          = 54;
  localparam int DepthOk         = 24;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_DEPTH_ERR = 2'd1,
    KIND_SIZE_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_RADIAL = 2'd0,
    MODE_KEY    = 2'd1,
    MODE_LUMA   = 2'd2,
    MODE_OPAQUE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXEL  = 2'd1,
    PH_PAD    = 2'd2,
    PH_IDLE   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_SCALE = 2'd1,
    CFG_KEY   = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_e;

  // One job handed from the parser to the alpha pipeline.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [11:0] col;
    logic [12:0] dy;
    logic [12:0] dx;
    logic        last;
  } job_t;

  // Gaussian falloff table entry, computed by the fixed-point recurrence.
  function automatic logic [7:0] exp_entry(input int idx);
    logic [63:0] r;
    logic [63:0] p;
    r = 64'd1 << 30;
    for (int i = 0; i < idx; i++) begin
      p = r * 64'd1069555701 + (64'd1 << 29);
      r = p >> 30;
    end
    p = 64'd255 * r;
    return p[37:30];
  endfunction

endpackage

// ===== rtl/bmp24_to_rgba_alpha_stream_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp24_to_rgba_alpha_stream_top: 24-bit BMP byte stream to RGBA pixels
// Parses the header, assembles pixels and computes alpha per mode.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid_i/in_ready_o  data_byte_i, file_start_i
//  out      out_valid_o/out_ready_i kind_o, red..alpha_o, pixel_row/col_o, last
//  cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while the job queue has room; the parser's counters update every byte.
// Each result passes through the job queue and the four alpha pipe stages.
// A two-entry queue sits between parser and alpha pipe; output stalls back up.
// Reset returns the parser to the header and the registers to defaults.
module bmp24_to_rgba_alpha_stream_top #(
  parameter int MAX_DIM         = bmp_pkg::MaxDimDefault,
  parameter int EXP_TABLE_DEPTH = bmp_pkg::ExpDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        file_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [11:0] pixel_row_o,
  output logic [11:0] pixel_col_o,
  output logic        last_pixel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [1:0]  mode_q;
  logic [31:0] scale_q;
  logic [7:0]  key_q;
  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  bmp_pkg::job_t fj, bj;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 2'd0; scale_q <= 32'd1048576; key_q <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (bmp_pkg::cfg_e'(cfg_index_i))
        bmp_pkg::CFG_MODE:  mode_q <= cfg_data_i[1:0];
        bmp_pkg::CFG_SCALE: scale_q <= cfg_data_i;
        bmp_pkg::CFG_KEY:   key_q <= cfg_data_i[7:0];
        bmp_pkg::CFG_NONE:  ;
      endcase
    end
  end

  bmp_front #(.MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .file_start_i,
    .job_valid_o(fj_valid), .job_o(fj), .job_ready_i(fj_ready)
  );

  bmp_fifo u_fifo (
    .clk_i, .rst_ni, .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  bmp_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
    .clk_i, .rst_ni, .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .alpha_mode_i(mode_q), .gauss_scale_i(scale_q), .key_threshold_i(key_q),
    .out_valid_o, .out_ready_i, .kind_o, .red_o, .green_o, .blue_o, .alpha_o,
    .pixel_row_o, .pixel_col_o, .last_pixel_o
  );

endmodule

// ===== rtl/bmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_front: header parser and pixel assembler
// Takes one file byte per cycle while the job queue has room and pushes pixel and error jobs.
// ----------------------------------------------------------------------------
module bmp_front #(
  parameter int MAX_DIM = bmp_pkg::MaxDimDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_byte_i,
  input  logic           file_start_i,
  output logic           job_valid_o,
  output bmp_pkg::job_t  job_o,
  input  logic           job_ready_i
);

  bmp_pkg::phase_e phase_q, phase_d;
  logic [5:0]  hcnt_q, hcnt_d;
  logic [31:0] width_q, width_d, height_q, height_d;
  logic [15:0] depth_q, depth_d;
  logic [1:0]  bip_q, bip_d, pad_q, pad_d;
  logic [7:0]  hb_q, hb_d, hg_q, hg_d;
  logic [13:0] row_q, row_d, col_q, col_d;
  logic [12:0] rcen_q, ccen_q;
  logic        push;
  bmp_pkg::job_t job;
  bmp_pkg::phase_e ph;
  logic [5:0]  hc;
  logic [31:0] w, h;
  logic [15:0] dp;
  logic [1:0]  bp;
  logic [12:0] r13, c13;
  logic        fire;

  // A byte is taken only when a job slot is free for it.
  assign in_ready_o  = job_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign job_valid_o = push;
  assign job_o       = job;

  always_comb begin
    ph = file_start_i ? bmp_pkg::PH_HEADER : phase_q;
    hc = file_start_i ? 6'd0 : hcnt_q;
    w  = file_start_i ? 32'd0 : width_q;
    h  = file_start_i ? 32'd0 : height_q;
    dp = file_start_i ? 16'd0 : depth_q;
    bp = file_start_i ? 2'd0 : bip_q;
    phase_d = phase_q; hcnt_d = hcnt_q; width_d = width_q; height_d = height_q;
    depth_d = depth_q; bip_d = bip_q; pad_d = pad_q; hb_d = hb_q; hg_d = hg_q;
    row_d = row_q; col_d = col_q;
    push = 1'b0;
    r13 = row_q[12:0];
    c13 = col_q[12:0];
    job = '0;
    job.kind  = bmp_pkg::KIND_PIXEL;
    job.red   = data_byte_i;
    job.green = hg_q;
    job.blue  = hb_q;
    job.row   = row_q[11:0];
    job.col   = col_q[11:0];
    job.dy    = (r13 >= rcen_q) ? r13 - rcen_q : rcen_q - r13;
    job.dx    = (c13 >= ccen_q) ? c13 - ccen_q : ccen_q - c13;
    job.last  = ({18'd0, row_q} + 32'd1 == height_q) &&
                ({18'd0, col_q} + 32'd1 == width_q);
    if (fire) begin
      phase_d = ph; hcnt_d = hc; width_d = w; height_d = h; depth_d = dp; bip_d = bp;
      if (file_start_i) begin
        hb_d = '0; hg_d = '0; row_d = '0; col_d = '0; pad_d = '0;
      end
      unique case (ph)
        bmp_pkg::PH_HEADER: begin
          if (hc >= 6'd18 && hc <= 6'd21)
            width_d = w | ({24'd0, data_byte_i} << (8 * (hc - 6'd18)));
          else if (hc >= 6'd22 && hc <= 6'd25)
            height_d = h | ({24'd0, data_byte_i} << (8 * (hc - 6'd22)));
          else if (hc == 6'd28) depth_d = {dp[15:8], dp[7:0] | data_byte_i};
          else if (hc == 6'd29) depth_d = {dp[15:8] | data_byte_i, dp[7:0]};
          if (hc != 6'(bmp_pkg::HdrLen - 1)) begin
            hcnt_d = hc + 6'd1;
          end else if (depth_d != 16'(bmp_pkg::DepthOk)) begin
            phase_d = bmp_pkg::PH_IDLE; push = 1'b1;
            job = '0; job.kind = bmp_pkg::KIND_DEPTH_ERR;
          end else if (width_d == 0 || width_d > 32'(MAX_DIM) || height_d == 0 ||
                       height_d > 32'(MAX_DIM)) begin
            phase_d = bmp_pkg::PH_IDLE; push = 1'b1;
            job = '0; job.kind = bmp_pkg::KIND_SIZE_ERR;
          end else begin
            phase_d = bmp_pkg::PH_PIXEL; bip_d = '0; row_d = '0; col_d = '0;
          end
        end
        bmp_pkg::PH_PAD: begin
          if (pad_q != 2'd0) pad_d = pad_q - 2'd1;
          if (pad_d == 2'd0)
            phase_d = ({18'd0, row_q} >= height_q) ? bmp_pkg::PH_IDLE : bmp_pkg::PH_PIXEL;
        end
        bmp_pkg::PH_PIXEL: begin
          if (bp == 2'd0) begin
            hb_d = data_byte_i; bip_d = 2'd1;
          end else if (bp == 2'd1) begin
            hg_d = data_byte_i; bip_d = 2'd2;
          end else begin
            bip_d = 2'd0; push = 1'b1;
            col_d = col_q + 14'd1;
            if ({18'd0, col_q} + 32'd1 >= width_q) begin
              col_d = '0; row_d = row_q + 14'd1;
              pad_d = width_q[1:0];
              if (width_q[1:0] != 2'd0) phase_d = bmp_pkg::PH_PAD;
              else if ({18'd0, row_q} + 32'd1 >= height_q) phase_d = bmp_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Parser state; the centre is registered once the sizes are known.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bmp_pkg::PH_HEADER; hcnt_q <= '0; width_q <= '0; height_q <= '0;
      depth_q <= '0; bip_q <= '0; pad_q <= '0; hb_q <= '0; hg_q <= '0;
      row_q <= '0; col_q <= '0; rcen_q <= '0; ccen_q <= '0;
    end else begin
      phase_q <= phase_d; hcnt_q <= hcnt_d; width_q <= width_d; height_q <= height_d;
      depth_q <= depth_d; bip_q <= bip_d; pad_q <= pad_d; hb_q <= hb_d; hg_q <= hg_d;
      row_q <= row_d; col_q <= col_d;
      rcen_q <= height_q[13:1]; ccen_q <= width_q[13:1];
    end
  end

endmodule

// ===== rtl/bmp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_fifo: two-entry job queue
// Decouples the parser from the alpha pipeline.
// ----------------------------------------------------------------------------
module bmp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  bmp_pkg::job_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output bmp_pkg::job_t rd_data_o
);

  bmp_pkg::job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== rtl/bmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_back: alpha pipeline
// Four stages: squares, scale product, table lookup, luma blend and output.
// ----------------------------------------------------------------------------
module bmp_back #(
  parameter int EXP_TABLE_DEPTH = bmp_pkg::ExpDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  input  bmp_pkg::job_t job_i,
  input  logic [1:0]    alpha_mode_i,
  input  logic [31:0]   gauss_scale_i,
  input  logic [7:0]    key_threshold_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    red_o,
  output logic [7:0]    green_o,
  output logic [7:0]    blue_o,
  output logic [7:0]    alpha_o,
  output logic [11:0]   pixel_row_o,
  output logic [11:0]   pixel_col_o,
  output logic          last_pixel_o
);

  localparam int IdxW = $clog2(EXP_TABLE_DEPTH);

  logic [7:0] rom [EXP_TABLE_DEPTH];
  always_comb begin
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) rom[i] = bmp_pkg::exp_entry(i);
  end

  logic [3:0] v_q;
  logic       adv;
  bmp_pkg::job_t j1_q, j2_q, j3_q, j4_q;
  logic [26:0] d2_q;
  logic [58:0] prod_q;
  logic [7:0]  g_q;
  logic [15:0] luma_q, luma2_q, luma3_q;
  logic [7:0]  a_q;
  logic [34:0] idx;
  logic        key_tr;
  logic [23:0] blend;
  logic        j1_key_q, j2_key_q, j3_key_q;

  // Whole pipeline moves when the output register is free.
  assign adv = !v_q[3] || out_ready_i;
  assign job_ready_o = adv;
  assign idx = prod_q[58:24];
  assign key_tr = job_i.red < key_threshold_i && job_i.green < key_threshold_i &&
                  job_i.blue < key_threshold_i;
  assign blend = luma3_q * g_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[2:0], job_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      j1_q <= job_i;
      d2_q <= 27'(job_i.dy) * 27'(job_i.dy) + 27'(job_i.dx) * 27'(job_i.dx);
      luma_q <= 16'd77 * job_i.red + 16'd151 * job_i.green + 16'd28 * job_i.blue;
      j2_q <= j1_q;
      luma2_q <= luma_q;
      prod_q <= {32'd0, d2_q} * {27'd0, gauss_scale_i};
      j3_q <= j2_q;
      luma3_q <= luma2_q;
      g_q <= (idx >= 35'(EXP_TABLE_DEPTH)) ? 8'd0 : rom[idx[IdxW-1:0]];
      j4_q <= j3_q;
      unique case (bmp_pkg::mode_e'(alpha_mode_i))
        bmp_pkg::MODE_RADIAL: a_q <= g_q;
        bmp_pkg::MODE_LUMA:   a_q <= blend[23:16];
        bmp_pkg::MODE_KEY:    a_q <= {8{!j3_key_q}};
        bmp_pkg::MODE_OPAQUE: a_q <= 8'hFF;
      endcase
    end
  end

  // Colour-key decision follows its job down the pipe.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      j1_key_q <= key_tr; j2_key_q <= j1_key_q; j3_key_q <= j2_key_q;
    end
  end

  assign out_valid_o  = v_q[3];
  assign kind_o       = j4_q.kind;
  assign red_o        = j4_q.red;
  assign green_o      = j4_q.green;
  assign blue_o       = j4_q.blue;
  assign alpha_o      = (j4_q.kind == bmp_pkg::KIND_PIXEL) ? a_q : 8'd0;
  assign pixel_row_o  = j4_q.row;
  assign pixel_col_o  = j4_q.col;
  assign last_pixel_o = j4_q.last;

endmodule
